// ===== sv/assert_macros.svh =====
// Assertion macros shared by the priority queue RTL.
// Included by modules that check their own invariants; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mpq assertion failed");
// Check a property on every rising clock edge, reset included.
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mpq assertion failed");
`else
`define MPQ_ASSERT(lbl, clk, rstn, prop)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/mpq_pkg.sv =====
// Types and constants of the max priority queue.
// Used by mpq_cell, max_priority_queue_unit and the testbench; no dependencies.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 11;

  // Command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  // Status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic                     keep;   // holds a value >= the one being inserted
    logic signed [ValueW-1:0] value;
  } mpq_link_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } mpq_ctrl_t;

endpackage

// ===== sv/max_priority_queue_unit.sv =====
// Max priority queue: a chain of DEPTH cells kept sorted, greatest at the head.
// Depends on mpq_pkg, mpq_cell and assert_macros.svh.
// Result: an accepted item's result is registered in the output register in the cycle after it is accepted.
// Throughput: 1 item per cycle while the output is not stalled; insert and remove each finish in one chain update.
// Reset: asynchronous, active low; clears all cell valid bits, count and output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module max_priority_queue_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic signed [mpq_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [mpq_pkg::ValueW-1:0] removed_value_o,
  output logic [mpq_pkg::OccW-1:0]          occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam mpq_pkg::mpq_link_t HeadLink = '{valid: 1'b1, keep: 1'b1, value: '0};
  localparam mpq_pkg::mpq_link_t TailLink = '{valid: 1'b0, keep: 1'b0, value: '0};

  logic [CntW-1:0]                   count_q, count_d;
  logic                              out_valid_q;
  logic [1:0]                        status_q, status_d;
  logic signed [mpq_pkg::ValueW-1:0] removed_q, removed_d;
  logic [mpq_pkg::OccW-1:0]          occ_q, occ_d;

  logic                 accept;
  logic                 full;
  logic                 empty;
  mpq_pkg::mpq_ctrl_t   ctrl;
  mpq_pkg::mpq_link_t   links [DEPTH];
  logic [DEPTH-1:0]     valid_vec;

  // Accept while the output register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.ins   = accept && (cmd_i == mpq_pkg::CmdInsert) && !full;
  assign ctrl.rem   = accept && (cmd_i == mpq_pkg::CmdRemove) && !empty;
  assign ctrl.value = value_i;

  // Cell chain, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_pkg::mpq_link_t left, right;
    if (i == 0) begin : g_head
      assign left = HeadLink;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = TailLink;
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    mpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  // Next count and result of the accepted item
  always_comb begin
    count_d   = count_q;
    status_d  = mpq_pkg::StatusDone;
    removed_d = '0;
    if (cmd_i == mpq_pkg::CmdInsert) begin
      if (full) begin
        status_d = mpq_pkg::StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = mpq_pkg::StatusEmpty;
      end else begin
        count_d   = count_q - CntW'(1);
        removed_d = links[0].value;
      end
    end
  end

  // Fit the count to the occupancy field
  if (CntW >= mpq_pkg::OccW) begin : g_occ_trunc
    assign occ_d = count_d[mpq_pkg::OccW-1:0];
  end else begin : g_occ_ext
    assign occ_d = {{(mpq_pkg::OccW - CntW){1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= occ_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = occ_q;

  // Count never exceeds the chain length
  `MPQ_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(DEPTH))
  // Valid cells match the count
  `MPQ_ASSERT(a_valid_count, clk_i, rst_ni, $countones(valid_vec) == 32'(count_q))
  // Removed value is not smaller than the new head
  `MPQ_ASSERT(a_rem_max, clk_i, rst_ni,
    ctrl.rem |=> (!links[0].valid || ($signed(removed_q) >= $signed(links[0].value))))
  // Insert into a full chain reports full and leaves the count
  `MPQ_ASSERT(a_full_drop, clk_i, rst_ni,
    (accept && (cmd_i == mpq_pkg::CmdInsert) && full) |=>
      ((status_q == mpq_pkg::StatusFull) && (count_q == CntW'(DEPTH))))
  // Output valid is low right after reset
  `MPQ_ASSERT_ALWAYS(a_reset_out, clk_i, !rst_ni |=> !out_valid_q || accept)

endmodule

// ===== sv/mpq_cell.sv =====
// One cell of the sorted register chain: holds one entry and its valid bit.
// Depends on mpq_pkg for the link and control structs.
`timescale 1ns / 1ps

module mpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpq_pkg::mpq_ctrl_t ctrl_i,
  input  mpq_pkg::mpq_link_t left_i,
  input  mpq_pkg::mpq_link_t right_i,
  output mpq_pkg::mpq_link_t link_o
);

  logic                              valid_q, valid_d;
  logic signed [mpq_pkg::ValueW-1:0] value_q, value_d;
  logic                              keep;

  // Keep own entry on insert when it is not smaller than the new item
  assign keep = valid_q && ($signed(value_q) >= $signed(ctrl_i.value));

  assign link_o.valid = valid_q;
  assign link_o.keep  = keep;
  assign link_o.value = value_q;

  // Insert: keep, take the new item, or shift in the left neighbor.
  // Remove: shift in the right neighbor.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (!keep) begin
        valid_d = valid_q | left_i.valid;
        value_d = left_i.keep ? ctrl_i.value : left_i.value;
      end
    end else if (ctrl_i.rem) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload needs no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== tb/max_priority_queue_unit_test.sv =====
// Self-checking testbench for max_priority_queue_unit: a table of directed items, then
// random inserts and removes under varied idling and a long output hold-off.
// Depends on mpq_pkg and max_priority_queue_unit.
`timescale 1ns / 1ps

module max_priority_queue_unit_test;

  localparam int unsigned ValueW = mpq_pkg::ValueW;
  localparam int unsigned OccW   = mpq_pkg::OccW;

  localparam int unsigned QueueDepth = 1024;
  localparam int RandomItems = 400;
  localparam int PhaseCount = 4;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 32;
  localparam int HoldOffCycles = 150;
  localparam logic signed [ValueW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] ValMin = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] removed;
    logic [OccW-1:0]          occupancy;
  } queue_result_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [ValueW-1:0] value;
    logic                     pinned;  // take the typed-in result, not the prediction
    queue_result_t            want;
  } directed_row_t;

  localparam int NumDirected = 25;
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusEmpty, 32'sd0, 11'd0}},
    '{mpq_pkg::CmdInsert, ValMax,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd1}},
    '{mpq_pkg::CmdInsert, ValMin,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd2}},
    '{mpq_pkg::CmdInsert, -32'sd1,        1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd3}},
    '{mpq_pkg::CmdInsert, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd4}},
    '{mpq_pkg::CmdInsert, 32'sd1,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd5}},
    '{mpq_pkg::CmdInsert, ValMax,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd6}},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  ValMax, 11'd5}},
    '{mpq_pkg::CmdRemove, -32'sd1,        1'b1, '{mpq_pkg::StatusDone,  ValMax, 11'd4}},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  32'sd1, 11'd3}},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  32'sd0, 11'd2}},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  -32'sd1, 11'd1}},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b1, '{mpq_pkg::StatusDone,  ValMin, 11'd0}},
    '{mpq_pkg::CmdRemove, ValMax,         1'b1, '{mpq_pkg::StatusEmpty, 32'sd0, 11'd0}},
    '{mpq_pkg::CmdInsert, 32'sh5555_5555, 1'b0, '0},
    '{mpq_pkg::CmdInsert, 32'shAAAA_AAAA, 1'b0, '0},
    '{mpq_pkg::CmdInsert, 32'sd42,        1'b0, '0},
    '{mpq_pkg::CmdInsert, 32'sd42,        1'b0, '0},
    '{mpq_pkg::CmdInsert, -32'sd42,       1'b0, '0},
    '{mpq_pkg::CmdRemove, ValMin,         1'b0, '0},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b0, '0},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b0, '0},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b0, '0},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b0, '0},
    '{mpq_pkg::CmdRemove, 32'sd0,         1'b0, '0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     cmd_i = mpq_pkg::CmdInsert;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [ValueW-1:0] removed_value_o;
  logic [OccW-1:0]          occupancy_o;

  // Shadow copy of the queue contents
  logic signed [ValueW-1:0] shadow_entries [QueueDepth];
  int unsigned              shadow_count = 0;
  queue_result_t            pending_results [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  max_priority_queue_unit #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one operation to the shadow queue and return what the block must answer
  function automatic queue_result_t predict_queue_op(input logic cmd,
                                                     input logic signed [ValueW-1:0] val);
    queue_result_t res;
    int unsigned best;
    res = '{mpq_pkg::StatusDone, '0, '0};
    if (cmd == mpq_pkg::CmdInsert) begin
      if (shadow_count >= QueueDepth) begin
        res.status = mpq_pkg::StatusFull;
      end else begin
        shadow_entries[shadow_count] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = mpq_pkg::StatusEmpty;
    end else begin
      // First index holding the greatest value wins ties
      best = 0;
      for (int unsigned i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i] > shadow_entries[best]) best = i;
      end
      res.removed = shadow_entries[best];
      shadow_count--;
      shadow_entries[best] = shadow_entries[shadow_count];
    end
    res.occupancy = shadow_count[OccW-1:0];
    return res;
  endfunction

  // Random value: many near zero for ties, some extremes, the rest anything
  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return $signed(ValueW'($urandom_range(4))) - 32'sd2;
    if (sel < 30) return ValMax;
    if (sel < 35) return ValMin;
    return $urandom;
  endfunction

  // Offer one item after a random gap, wait for it to be taken, then record its result
  task automatic offer_item(input logic cmd, input logic signed [ValueW-1:0] val,
                            input logic pinned, input queue_result_t want);
    queue_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    res = predict_queue_op(cmd, val);
    pending_results.push_back(pinned ? want : res);
  endtask

  // Receiver: random stalls, plus long hold-offs counted here on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldOffCycles;
      end
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  // Check each result against the oldest expectation; watch for a hung block
  initial begin
    queue_result_t want;
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles = 0;
      end else if (rst_ni) begin
        quiet_cycles++;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (removed_value_o !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value_o);
            mismatches++;
          end
          if (occupancy_o !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
            mismatches++;
          end
        end
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic cmd;
    int insert_pct;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < NumDirected; r++) begin
      offer_item(DirectedRows[r].cmd, DirectedRows[r].value,
                 DirectedRows[r].pinned, DirectedRows[r].want);
    end

    // Random mix, one idling pattern per phase
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // hold the output off long enough that the input backs up
          hold_requests++;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < RandomItems / PhaseCount; n++) begin
        insert_pct = (shadow_count < 20) ? 55 : 35;
        cmd = ($urandom_range(99) < insert_pct) ? mpq_pkg::CmdInsert : mpq_pkg::CmdRemove;
        offer_item(cmd, pick_value(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;

    // Wait out the remaining results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mpq_pkg.sv
sv/mpq_cell.sv
sv/max_priority_queue_unit.sv
tb/max_priority_queue_unit_test.sv
